[rtl/nphe_pkg.sv]
// nphe_pkg: shared types and constants for the nand page hamming ecc block
// used by the channel interfaces, the parity term logic, the core and the top level
`default_nettype none

package nphe_pkg;

  localparam int WORD_W      = 11;
  localparam int COUNT_W     = 16;
  localparam int BLOCK_BYTES = 256;
  localparam int POS_W       = 8;

  localparam logic [WORD_W-1:0]  WORD_ZERO  = '0;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] BLOCK_SIZE = COUNT_W'(BLOCK_BYTES);
  localparam logic [COUNT_W-1:0] PAGE_SMALL = COUNT_W'(BLOCK_BYTES);
  localparam logic [COUNT_W-1:0] PAGE_LARGE = COUNT_W'(2 * BLOCK_BYTES);

  // column parity masks, odd and even groups
  localparam logic [7:0] MASK_P1_ODD  = 8'hAA;
  localparam logic [7:0] MASK_P1_EVEN = 8'h55;
  localparam logic [7:0] MASK_P2_ODD  = 8'hCC;
  localparam logic [7:0] MASK_P2_EVEN = 8'h33;
  localparam logic [7:0] MASK_P4_ODD  = 8'hF0;
  localparam logic [7:0] MASK_P4_EVEN = 8'h0F;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_LOAD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] count_value;
  } nphe_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  ecc_first_odd;
    logic [WORD_W-1:0]  ecc_first_even;
    logic [WORD_W-1:0]  ecc_second_odd;
    logic [WORD_W-1:0]  ecc_second_even;
    logic [COUNT_W-1:0] byte_count;
    logic               page_complete;
  } nphe_result_t;

endpackage

`default_nettype wire

[rtl/nphe_in_if.sv]
// nphe_in_if: input channel carrying one page item per transaction
// depends on nphe_pkg for field widths
`default_nettype none

interface nphe_in_if;
  import nphe_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         data_byte;
  logic [COUNT_W-1:0] count_value;

  modport source (output valid, output kind, output data_byte, output count_value,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input count_value,
                  output ready);
endinterface

`default_nettype wire

[rtl/nphe_out_if.sv]
// nphe_out_if: result channel carrying the ecc words and byte count
// depends on nphe_pkg for field widths
`default_nettype none

interface nphe_out_if;
  import nphe_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  ecc_first_odd;
  logic [WORD_W-1:0]  ecc_first_even;
  logic [WORD_W-1:0]  ecc_second_odd;
  logic [WORD_W-1:0]  ecc_second_even;
  logic [COUNT_W-1:0] byte_count;
  logic               page_complete;

  modport source (output valid, output ecc_first_odd, output ecc_first_even,
                  output ecc_second_odd, output ecc_second_even,
                  output byte_count, output page_complete, input ready);
  modport sink   (input valid, input ecc_first_odd, input ecc_first_even,
                  input ecc_second_odd, input ecc_second_even,
                  input byte_count, input page_complete, output ready);
endinterface

`default_nettype wire

[rtl/nphe_absorb.sv]
// nphe_absorb: odd and even parity terms contributed by one data byte
// depends on nphe_pkg for word width and column masks
`default_nettype none

module nphe_absorb (
  input  wire logic [7:0]                 data_byte,
  input  wire logic [nphe_pkg::POS_W-1:0] pos,
  output logic [nphe_pkg::WORD_W-1:0]     odd_term,
  output logic [nphe_pkg::WORD_W-1:0]     even_term
);
  import nphe_pkg::*;

  logic line_par;

  assign line_par = ^data_byte;

  always_comb begin
    odd_term     = WORD_ZERO;
    even_term    = WORD_ZERO;
    odd_term[0]  = ^(data_byte & MASK_P1_ODD);
    even_term[0] = ^(data_byte & MASK_P1_EVEN);
    odd_term[1]  = ^(data_byte & MASK_P2_ODD);
    even_term[1] = ^(data_byte & MASK_P2_EVEN);
    odd_term[2]  = ^(data_byte & MASK_P4_ODD);
    even_term[2] = ^(data_byte & MASK_P4_EVEN);
    // line parity goes to the odd word where the position bit is set
    for (int k = 0; k < POS_W; k++) begin
      odd_term[3+k]  = line_par & pos[k];
      even_term[3+k] = line_par & ~pos[k];
    end
  end
endmodule

`default_nettype wire

[rtl/nphe_core.sv]
// nphe_core: parity word and byte count registers with their per-item update
// depends on nphe_pkg and nphe_absorb
`default_nettype none

module nphe_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  take,
  input  wire nphe_pkg::nphe_item_t  item,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_wr_data,
  output nphe_pkg::nphe_result_t     result_nxt
);
  import nphe_pkg::*;

  logic [WORD_W-1:0]  first_odd_r,  first_odd_nxt;
  logic [WORD_W-1:0]  first_even_r, first_even_nxt;
  logic [WORD_W-1:0]  second_odd_r, second_odd_nxt;
  logic [WORD_W-1:0]  second_even_r, second_even_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               large_page_r;
  logic [WORD_W-1:0]  odd_term, even_term;
  logic [COUNT_W-1:0] page_size;
  kind_t              kind;

  assign kind = kind_t'(item.kind);

  nphe_absorb u_absorb (
    .data_byte (item.data_byte),
    .pos       (count_r[POS_W-1:0]),
    .odd_term  (odd_term),
    .even_term (even_term)
  );

  always_comb begin
    first_odd_nxt   = first_odd_r;
    first_even_nxt  = first_even_r;
    second_odd_nxt  = second_odd_r;
    second_even_nxt = second_even_r;
    count_nxt       = count_r;
    case (kind)
      KIND_DATA: begin
        if (count_r < BLOCK_SIZE) begin
          first_odd_nxt  = first_odd_r ^ odd_term;
          first_even_nxt = first_even_r ^ even_term;
        end else begin
          second_odd_nxt  = second_odd_r ^ odd_term;
          second_even_nxt = second_even_r ^ even_term;
        end
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_CLEAR: begin
        first_odd_nxt   = WORD_ZERO;
        first_even_nxt  = WORD_ZERO;
        second_odd_nxt  = WORD_ZERO;
        second_even_nxt = WORD_ZERO;
        count_nxt       = '0;
      end
      KIND_LOAD: begin
        count_nxt = item.count_value;
      end
      default: begin
        // unused kind leaves the state as is
      end
    endcase
  end

  assign page_size = large_page_r ? PAGE_LARGE : PAGE_SMALL;

  always_comb begin
    result_nxt.ecc_first_odd   = first_odd_nxt;
    result_nxt.ecc_first_even  = first_even_nxt;
    result_nxt.ecc_second_odd  = second_odd_nxt;
    result_nxt.ecc_second_even = second_even_nxt;
    result_nxt.byte_count      = count_nxt;
    result_nxt.page_complete   = (count_nxt >= page_size);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_odd_r   <= WORD_ZERO;
      first_even_r  <= WORD_ZERO;
      second_odd_r  <= WORD_ZERO;
      second_even_r <= WORD_ZERO;
      count_r       <= '0;
    end else if (take) begin
      first_odd_r   <= first_odd_nxt;
      first_even_r  <= first_even_nxt;
      second_odd_r  <= second_odd_nxt;
      second_even_r <= second_even_nxt;
      count_r       <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_page_r <= 1'b0;
    end else if (cfg_wr_en) begin
      large_page_r <= cfg_wr_data;
    end
  end

`ifndef ASSERT_OFF
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && take && kind == KIND_CLEAR |=>
      count_r == '0 && first_odd_r == WORD_ZERO && second_even_r == WORD_ZERO)
    else $error("clear left state nonzero");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && take && kind == KIND_DATA && count_r == COUNT_MAX |=> count_r == COUNT_MAX)
    else $error("byte count wrapped past saturation");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !take |=> $stable(count_r) && $stable(first_odd_r) && $stable(second_odd_r))
    else $error("state changed without a transaction");

  a_first_block_only: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && take && kind == KIND_DATA && count_r < BLOCK_SIZE |=>
      $stable(second_odd_r) && $stable(second_even_r))
    else $error("first block byte touched the second pair");
`endif
endmodule

`default_nettype wire

[rtl/nand_page_hamming_ecc_top.sv]
// nand_page_hamming_ecc_top: nand page hamming ecc accumulator with output register
// depends on nphe_pkg, nphe_in_if, nphe_out_if and nphe_core
//
//   channel   direction  handshake        payload
//   in_chan   sink       valid/ready      kind, data_byte, count_value
//   out_chan  source     valid/ready      four ecc words, byte_count, page_complete
//   cfg       write      cfg_wr_en        cfg_wr_data (large_page)
//
// one transaction per cycle while in_chan is ready: the state update is an xor and increment
// on the accumulator registers, and the result sits in one output register.
// each accepted item yields its result from the output register in the next cycle.
// in_chan is ready whenever the output register is empty or being taken.
// rst_n is synchronous and clears the ecc words, the count and large_page.
`default_nettype none

module nand_page_hamming_ecc_top (
  input  wire logic clk,
  input  wire logic rst_n,
  nphe_in_if.sink   in_chan,
  nphe_out_if.source out_chan,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);
  import nphe_pkg::*;

  logic         out_valid_r;
  nphe_result_t result_nxt;
  nphe_result_t result_r;
  nphe_item_t   item;
  logic         take;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign take          = in_chan.valid && in_chan.ready;

  assign item.kind        = in_chan.kind;
  assign item.data_byte   = in_chan.data_byte;
  assign item.count_value = in_chan.count_value;

  nphe_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result_nxt  (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.ecc_first_odd   = result_r.ecc_first_odd;
  assign out_chan.ecc_first_even  = result_r.ecc_first_even;
  assign out_chan.ecc_second_odd  = result_r.ecc_second_odd;
  assign out_chan.ecc_second_even = result_r.ecc_second_even;
  assign out_chan.byte_count      = result_r.byte_count;
  assign out_chan.page_complete   = result_r.page_complete;
endmodule

`default_nettype wire

[sim/tb.sv]
// tb: self-checking bench for nand_page_hamming_ecc_top, one result per page item
// depends on nphe_pkg, nphe_in_if, nphe_out_if and the rtl top level
`timescale 1ns / 100ps

module tb;
  import nphe_pkg::*;

  localparam logic [1:0] KIND_UNUSED     = 2'd3;
  localparam int         ITEMS_PER_PHASE = 400;
  localparam int         NUM_PHASES      = 4;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         DRAIN_CYCLES    = 4;
  localparam int         CYCLE_LIMIT     = 1000000;

  typedef struct packed {
    nphe_item_t   item;
    bit           typed;
    nphe_result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  nphe_in_if  in_if ();
  nphe_out_if out_if ();

  nand_page_hamming_ecc_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  logic [WORD_W-1:0]  ecc_words [4];
  logic [COUNT_W-1:0] byte_cnt;
  bit                 large_page_cfg;

  nphe_result_t pending_ecc [$];
  dir_row_t     dir_rows [$];
  int           mismatch_cnt;
  int           sent_cnt;
  int           cycle_cnt;
  bit           tx_idle;
  bit           hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic nphe_item_t page_item(input logic [1:0] k, input logic [7:0] d,
                                           input logic [COUNT_W-1:0] cv);
    nphe_item_t it;
    it.kind        = k;
    it.data_byte   = d;
    it.count_value = cv;
    return it;
  endfunction

  // advances the ecc state by one transaction and returns the snapshot it shows
  function automatic nphe_result_t apply_page_item(input nphe_item_t it);
    logic [WORD_W-1:0] odd_t;
    logic [WORD_W-1:0] even_t;
    logic [POS_W-1:0]  pos;
    logic              line_par;
    nphe_result_t      r;
    int                k;
    odd_t  = '0;
    even_t = '0;
    case (it.kind)
      KIND_DATA: begin
        pos       = byte_cnt[POS_W-1:0];
        line_par  = ^it.data_byte;
        odd_t[0]  = ^(it.data_byte & MASK_P1_ODD);
        even_t[0] = ^(it.data_byte & MASK_P1_EVEN);
        odd_t[1]  = ^(it.data_byte & MASK_P2_ODD);
        even_t[1] = ^(it.data_byte & MASK_P2_EVEN);
        odd_t[2]  = ^(it.data_byte & MASK_P4_ODD);
        even_t[2] = ^(it.data_byte & MASK_P4_EVEN);
        for (k = 0; k < POS_W; k++) begin
          if (pos[k]) odd_t[3+k] = line_par;
          else        even_t[3+k] = line_par;
        end
        if (byte_cnt < BLOCK_SIZE) begin
          ecc_words[0] = ecc_words[0] ^ odd_t;
          ecc_words[1] = ecc_words[1] ^ even_t;
        end else begin
          ecc_words[2] = ecc_words[2] ^ odd_t;
          ecc_words[3] = ecc_words[3] ^ even_t;
        end
        if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 1'b1;
      end
      KIND_CLEAR: begin
        for (k = 0; k < 4; k++) ecc_words[k] = WORD_ZERO;
        byte_cnt = '0;
      end
      KIND_LOAD: begin
        byte_cnt = it.count_value;
      end
      default: begin
      end
    endcase
    r.ecc_first_odd   = ecc_words[0];
    r.ecc_first_even  = ecc_words[1];
    r.ecc_second_odd  = ecc_words[2];
    r.ecc_second_even = ecc_words[3];
    r.byte_count      = byte_cnt;
    r.page_complete   = byte_cnt >= (large_page_cfg ? PAGE_LARGE : PAGE_SMALL);
    return r;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    else if (r < 94) return $urandom_range(1, 3);
    else return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic add_directed(input logic [1:0] k, input logic [7:0] d,
                              input logic [COUNT_W-1:0] cv, input bit typed = 1'b0,
                              input logic [WORD_W-1:0] first_even = '0,
                              input logic [COUNT_W-1:0] cnt = '0, input bit pc = 1'b0);
    dir_row_t row;
    row.item                = page_item(k, d, cv);
    row.typed               = typed;
    row.want                = '0;
    row.want.ecc_first_even = first_even;
    row.want.byte_count     = cnt;
    row.want.page_complete  = pc;
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input nphe_item_t it, input bit typed = 1'b0,
                           input nphe_result_t want = '0);
    nphe_result_t model_res;
    int           gap;
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.kind        <= it.kind;
    in_if.data_byte   <= it.data_byte;
    in_if.count_value <= it.count_value;
    do @(posedge clk); while (!in_if.ready);
    model_res = apply_page_item(it);
    pending_ecc.push_back(typed ? want : model_res);
    if (it.kind != KIND_UNUSED) sent_cnt++;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // a run stops early once the phase has sent its share
  task automatic send_data_run(input int n, input int stop_at);
    repeat (n)
      if (sent_cnt < stop_at)
        send_item(page_item(KIND_DATA, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535))));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_ecc.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_page_mode(input bit large_mode);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= large_mode;
    @(posedge clk);
    large_page_cfg = large_mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int stall_left;
    int mode_left;
    bit rx_idle;
    out_if.ready = 1'b0;
    stall_left   = 0;
    mode_left    = 0;
    rx_idle      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (mode_left == 0) begin
        rx_idle   = $urandom_range(0, 2) != 0;
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (rx_idle) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    nphe_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_ecc.size() == 0) begin
        report_mismatch("unexpected transaction, byte_count", out_if.byte_count, 0);
      end else begin
        want = pending_ecc.pop_front();
        if (out_if.ecc_first_odd !== want.ecc_first_odd)
          report_mismatch("ecc_first_odd", out_if.ecc_first_odd, want.ecc_first_odd);
        if (out_if.ecc_first_even !== want.ecc_first_even)
          report_mismatch("ecc_first_even", out_if.ecc_first_even, want.ecc_first_even);
        if (out_if.ecc_second_odd !== want.ecc_second_odd)
          report_mismatch("ecc_second_odd", out_if.ecc_second_odd, want.ecc_second_odd);
        if (out_if.ecc_second_even !== want.ecc_second_even)
          report_mismatch("ecc_second_even", out_if.ecc_second_even, want.ecc_second_even);
        if (out_if.byte_count !== want.byte_count)
          report_mismatch("byte_count", out_if.byte_count, want.byte_count);
        if (out_if.page_complete !== want.page_complete)
          report_mismatch("page_complete", out_if.page_complete, want.page_complete);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int               phase;
    int               phase_end;
    int               burst;
    int               pick;
    int               page_len;
    logic [COUNT_W-1:0] cv;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_DATA;
    in_if.data_byte   = '0;
    in_if.count_value = '0;
    for (int i = 0; i < 4; i++) ecc_words[i] = WORD_ZERO;
    byte_cnt       = '0;
    large_page_cfg = 1'b0;
    mismatch_cnt   = 0;
    sent_cnt       = 0;
    cycle_cnt      = 0;
    hold_req       = 1'b0;
    tx_idle        = 1'b1;

    // directed rows, 256-byte page mode from reset
    add_directed(KIND_CLEAR,  8'hFF, 16'hFFFF, 1'b1, 11'h000, 16'd0, 1'b0);
    add_directed(KIND_DATA,   8'h00, 16'hFFFF, 1'b1, 11'h000, 16'd1, 1'b0);
    add_directed(KIND_CLEAR,  8'h00, 16'h0000, 1'b1, 11'h000, 16'd0, 1'b0);
    // single low bit at position 0 sets every even term
    add_directed(KIND_DATA,   8'h01, 16'h0000, 1'b1, 11'h7FF, 16'd1, 1'b0);
    add_directed(KIND_DATA,   8'hFF, 16'h0000);
    add_directed(KIND_DATA,   8'h80, 16'h0000);
    add_directed(KIND_UNUSED, 8'hFF, 16'hFFFF);
    add_directed(KIND_DATA,   8'h7F, 16'h0000);
    add_directed(KIND_LOAD,   8'h00, 16'h00FF);
    add_directed(KIND_DATA,   8'hA5, 16'h0000);
    add_directed(KIND_DATA,   8'h5A, 16'h0000);
    add_directed(KIND_DATA,   8'h01, 16'h0000);
    add_directed(KIND_CLEAR,  8'hAA, 16'h5555, 1'b1, 11'h000, 16'd0, 1'b0);
    add_directed(KIND_LOAD,   8'h00, 16'd255,  1'b1, 11'h000, 16'd255, 1'b0);
    add_directed(KIND_LOAD,   8'h00, 16'd256,  1'b1, 11'h000, 16'd256, 1'b1);
    add_directed(KIND_LOAD,   8'hFF, 16'hFFFF, 1'b1, 11'h000, 16'hFFFF, 1'b1);
    // bytes at a saturated count stay in the second block at position 0xff
    add_directed(KIND_DATA,   8'h01, 16'h0000);
    add_directed(KIND_DATA,   8'hFE, 16'h0000);
    add_directed(KIND_LOAD,   8'h00, 16'h8000);
    add_directed(KIND_DATA,   8'hC3, 16'h0000);
    add_directed(KIND_DATA,   8'h3C, 16'h0000);
    add_directed(KIND_LOAD,   8'hFF, 16'h0000);
    add_directed(KIND_DATA,   8'h55, 16'hFFFF);
    add_directed(KIND_CLEAR,  8'h00, 16'h0000, 1'b1, 11'h000, 16'd0, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      set_page_mode(phase % 2 == 0);
      phase_end = sent_cnt + ITEMS_PER_PHASE;
      burst     = 0;
      while (sent_cnt < phase_end) begin
        tx_idle = $urandom_range(0, 3) != 0;
        // sink holds off while the source keeps pushing
        if (phase == 1 && burst == 0) begin
          hold_req = 1'b1;
          tx_idle  = 1'b0;
        end
        if (phase == 2 && burst == 4) drain_results();
        page_len = large_page_cfg ? 2 * BLOCK_BYTES : BLOCK_BYTES;
        pick     = $urandom_range(0, 99);
        if (pick < 45) begin
          send_item(page_item(KIND_CLEAR, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535))));
          send_data_run(page_len - 2 + $urandom_range(0, 4), phase_end);
        end else if (pick < 65) begin
          // start at or just short of a block or page boundary
          cv = 16'(($urandom_range(0, 1) ? 2 : 1) * BLOCK_BYTES - $urandom_range(0, 6));
          send_item(page_item(KIND_LOAD, 8'($urandom_range(0, 255)), cv));
          send_data_run($urandom_range(4, 20), phase_end);
        end else if (pick < 75) begin
          cv = COUNT_MAX - 16'($urandom_range(0, 5));
          send_item(page_item(KIND_LOAD, 8'($urandom_range(0, 255)), cv));
          send_data_run($urandom_range(3, 10), phase_end);
        end else if (pick < 90) begin
          send_data_run($urandom_range(1, 30), phase_end);
        end else begin
          send_item(page_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535))));
        end
        burst++;
      end
    end

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/nphe_pkg.sv
rtl/nphe_in_if.sv
rtl/nphe_out_if.sv
rtl/nphe_absorb.sv
rtl/nphe_core.sv
rtl/nand_page_hamming_ecc_top.sv
sim/tb.sv
